/* hw/rtl/vmsg_pkg.sv */
// vmsg_pkg: constants, register indexes and the cordic angle table
// for the vector move step generator; no dependencies
package vmsg_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int SEG_W        = 7;
   localparam int LEN_W        = 17;
   localparam int HEAD_W       = 16;
   localparam int RATE_W       = 16;
   localparam int CNT_W        = 16;
   localparam int RES_W        = 18;
   localparam int CORDIC_ITERS = 16;
   localparam int CSR_ADDR_W   = 4;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 40;

   localparam logic [RATE_W-1:0] X_RATE_RESET = 16'd1869;
   localparam logic [RATE_W-1:0] Z_RATE_RESET = 16'd1894;
   localparam logic [SEG_W-1:0]  SEG_RESET    = 7'd64;
   localparam logic [32:0]       CORDIC_INV_GAIN = 33'd652032874;

   localparam logic [1:0] REG_X_RATE = 2'd0;
   localparam logic [1:0] REG_Z_RATE = 2'd1;
   localparam logic [1:0] REG_SEGS   = 2'd2;

   function automatic logic [21:0] atan_turn24(input logic [3:0] idx);
      logic [21:0] v;
      case (idx)
         4'd0:    v = 22'd2097152;
         4'd1:    v = 22'd1238021;
         4'd2:    v = 22'd654136;
         4'd3:    v = 22'd332050;
         4'd4:    v = 22'd166669;
         4'd5:    v = 22'd83416;
         4'd6:    v = 22'd41718;
         4'd7:    v = 22'd20860;
         4'd8:    v = 22'd10430;
         4'd9:    v = 22'd5215;
         4'd10:   v = 22'd2608;
         4'd11:   v = 22'd1304;
         4'd12:   v = 22'd652;
         4'd13:   v = 22'd326;
         4'd14:   v = 22'd163;
         default: v = 22'd81;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/vector_move_step_generator.sv */
// vector_move_step_generator: top level, resolves a move vector into
// per-segment x and z step counts; depends on vmsg_pkg
//
// usage: one move vector enters on the req_ stream (length in 1/256 mm,
// heading in 1/65536 turn). it is resolved into x and z parts by a
// 16-iteration cordic, each part is divided once by the segment count
// in a bit-serial divider, and then each segment is produced with a
// running remainder and a shared 17x16 multiplier. the rsp_ stream
// carries one transfer per segment, tlast on the last. req_tready is
// high only while idle. a stalled receiver holds the pending result
// and the block waits. reset (synchronous) restores the registers to
// their defaults and clears both axis residues. the csr_ port writes
// the x step rate, the z step rate and the segment count at byte
// addresses 0, 4 and 8.
module vector_move_step_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // length_mm[16:0], heading[32:17], zero pad
   input  logic [vmsg_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // x_step_count[15:0], x_forward[16], z_step_count[32:17], z_forward[33], zero pad
   output logic [vmsg_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [vmsg_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import vmsg_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_ROT  = 11'b000_0000_0010,
      ST_TRIG = 11'b000_0000_0100,
      ST_MULP = 11'b000_0000_1000,
      ST_DIV  = 11'b000_0001_0000,
      ST_SEG  = 11'b000_0010_0000,
      ST_MLO  = 11'b000_0100_0000,
      ST_MHI  = 11'b000_1000_0000,
      ST_TOT  = 11'b001_0000_0000,
      ST_RES  = 11'b010_0000_0000,
      ST_OUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [RATE_W-1:0] x_rate_ff, z_rate_ff;
   logic [SEG_W-1:0]  segs_ff;

   logic signed [LEN_W-1:0] len_ff;
   logic [HEAD_W-1:0]       head_ff;
   logic [SEG_W-1:0]        n_ff;
   logic signed [32:0]      cx_ff, cy_ff;
   logic signed [24:0]      cz_ff;
   logic [3:0]              it_ff;
   logic signed [17:0]      cq_ff, sq_ff;
   logic                    ax_ff;
   logic [32:0]             dvd_ff;
   logic [6:0]              rem_ff;
   logic [5:0]              dcnt_ff;
   logic [32:0]             qd_ff [2];
   logic [6:0]              rd_ff [2];
   logic                    neg_ff [2];
   logic [6:0]              racc_ff [2];
   logic signed [RES_W-1:0] res_ff [2];
   logic [32:0]             dm_ff;
   logic [48:0]             acc_ff;
   logic signed [35:0]      tot_ff;
   logic [SEG_W-1:0]        seg_ff;
   logic [CNT_W-1:0]        cnt_ff [2];
   logic                    fwd_ff [2];

   // configuration port
   logic       wr_en;
   logic [1:0] wr_idx;
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx     = csr_paddr[3:2];

   always_comb begin
      unique case (wr_idx)
         REG_X_RATE: csr_prdata = {16'd0, x_rate_ff};
         REG_Z_RATE: csr_prdata = {16'd0, z_rate_ff};
         REG_SEGS:   csr_prdata = {25'd0, segs_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_rate_ff <= X_RATE_RESET;
         z_rate_ff <= Z_RATE_RESET;
         segs_ff   <= SEG_RESET;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_X_RATE: x_rate_ff <= csr_pwdata[RATE_W-1:0];
            REG_Z_RATE: z_rate_ff <= csr_pwdata[RATE_W-1:0];
            REG_SEGS:   segs_ff   <= csr_pwdata[SEG_W-1:0];
            default:    ;
         endcase
      end
   end

   // handshake
   logic req_xfer, rsp_xfer;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_tvalid & rsp_tready;
   assign rsp_tlast  = (seg_ff == n_ff);
   assign rsp_tdata  = {6'd0, fwd_ff[1], cnt_ff[1], fwd_ff[0], cnt_ff[0]};

   // segment count clamp
   logic [SEG_W-1:0] n_in;
   always_comb begin
      if (segs_ff == '0)                            n_in = SEG_W'(1);
      else if (segs_ff > SEG_W'(MAX_SEGMENTS))      n_in = SEG_W'(MAX_SEGMENTS);
      else                                          n_in = segs_ff;
   end

   // cordic step
   logic signed [32:0] xs, ys;
   logic signed [24:0] at;
   assign xs = cx_ff >>> it_ff;
   assign ys = cy_ff >>> it_ff;
   assign at = 25'(atan_turn24(it_ff));

   // rounding, clamp and quadrant mapping
   logic signed [32:0] cr, sr;
   logic signed [17:0] cc, sc, cq_in, sq_in;
   always_comb begin
      cr = (cx_ff + 33'sd8192) >>> 14;
      sr = (cy_ff + 33'sd8192) >>> 14;
      if (cr > 33'sd65536)       cc = 18'sd65536;
      else if (cr < -33'sd65536) cc = -18'sd65536;
      else                       cc = cr[17:0];
      if (sr > 33'sd65536)       sc = 18'sd65536;
      else if (sr < -33'sd65536) sc = -18'sd65536;
      else                       sc = sr[17:0];
      case (head_ff[15:14])
         2'd0:    begin cq_in = cc;  sq_in = sc;  end
         2'd1:    begin cq_in = -sc; sq_in = cc;  end
         2'd2:    begin cq_in = -cc; sq_in = -sc; end
         default: begin cq_in = sc;  sq_in = -cc; end
      endcase
   end

   // axis total
   logic signed [17:0] trig_sel;
   logic signed [34:0] ptot;
   logic [34:0]        pmag;
   assign trig_sel = ax_ff ? sq_ff : cq_ff;
   assign ptot     = 35'(len_ff) * 35'(trig_sel);
   assign pmag     = ptot[34] ? 35'(-ptot) : ptot;

   // restoring divider step
   logic [7:0] rem_t;
   logic       qbit;
   assign rem_t = {rem_ff, dvd_ff[32]};
   assign qbit  = (rem_t >= {1'b0, n_ff});

   // segment remainder step
   logic [7:0] racc_t;
   logic       carry;
   assign racc_t = {1'b0, racc_ff[ax_ff]} + {1'b0, rd_ff[ax_ff]};
   assign carry  = (racc_t >= {1'b0, n_ff});

   // shared multiplier
   logic [RATE_W-1:0] rate_sel;
   logic [16:0]       m_a;
   logic [32:0]       m_p;
   assign rate_sel = ax_ff ? z_rate_ff : x_rate_ff;
   assign m_a      = (state_ff == ST_MLO) ? dm_ff[16:0] : {1'b0, dm_ff[32:17]};
   assign m_p      = 33'(m_a) * 33'(rate_sel);

   // rounding to 2^-16 step and residue add
   logic [33:0]        qv;
   logic signed [35:0] res_x;
   assign qv    = 34'((acc_ff + 49'd32768) >> 16);
   assign res_x = 36'(res_ff[ax_ff]);

   // whole steps and new residue
   logic [35:0] tmag;
   logic [19:0] steps;
   logic [15:0] frac;
   assign tmag  = tot_ff[35] ? 36'(-tot_ff) : tot_ff;
   assign steps = tmag[35:16];
   assign frac  = tmag[15:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_ROT;
         ST_ROT:  if (it_ff == 4'(CORDIC_ITERS - 1)) state_in = ST_TRIG;
         ST_TRIG: state_in = ST_MULP;
         ST_MULP: state_in = ST_DIV;
         ST_DIV:  if (dcnt_ff == 6'd32) state_in = ax_ff ? ST_SEG : ST_MULP;
         ST_SEG:  state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_TOT;
         ST_TOT:  state_in = ST_RES;
         ST_RES:  state_in = ax_ff ? ST_OUT : ST_SEG;
         ST_OUT:  if (rsp_xfer) state_in = (seg_ff == n_ff) ? ST_IDLE : ST_SEG;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_ff[0] <= '0;
         res_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RES)
            res_ff[ax_ff] <= tot_ff[35] ? -RES_W'({2'b0, frac}) : RES_W'({2'b0, frac});
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            len_ff  <= req_tdata[16:0];
            head_ff <= req_tdata[32:17];
            n_ff    <= n_in;
            cx_ff   <= CORDIC_INV_GAIN;
            cy_ff   <= '0;
            cz_ff   <= 25'({req_tdata[30:17], 8'd0});
            it_ff   <= '0;
         end
         ST_ROT: begin
            if (!cz_ff[24]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - at;
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + at;
            end
            it_ff <= it_ff + 4'd1;
         end
         ST_TRIG: begin
            cq_ff <= cq_in;
            sq_ff <= sq_in;
            ax_ff <= 1'b0;
         end
         ST_MULP: begin
            neg_ff[ax_ff] <= ptot[34];
            dvd_ff        <= pmag[32:0];
            rem_ff        <= '0;
            dcnt_ff       <= '0;
         end
         ST_DIV: begin
            rem_ff  <= qbit ? 7'(rem_t - {1'b0, n_ff}) : rem_t[6:0];
            dvd_ff  <= {dvd_ff[31:0], qbit};
            dcnt_ff <= dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd32) begin
               qd_ff[ax_ff]   <= {dvd_ff[31:0], qbit};
               rd_ff[ax_ff]   <= qbit ? 7'(rem_t - {1'b0, n_ff}) : rem_t[6:0];
               racc_ff[ax_ff] <= '0;
               ax_ff          <= ~ax_ff;
               seg_ff         <= SEG_W'(1);
            end
         end
         ST_SEG: begin
            racc_ff[ax_ff] <= carry ? 7'(racc_t - {1'b0, n_ff}) : racc_t[6:0];
            dm_ff          <= qd_ff[ax_ff] + 33'(carry);
         end
         ST_MLO: acc_ff <= 49'(m_p);
         ST_MHI: acc_ff <= acc_ff + {m_p[31:0], 17'd0};
         ST_TOT: tot_ff <= (neg_ff[ax_ff] ? -36'(qv) : 36'(qv)) + res_x;
         ST_RES: begin
            cnt_ff[ax_ff] <= (steps > 20'd65535) ? 16'hFFFF : steps[15:0];
            fwd_ff[ax_ff] <= !(neg_ff[ax_ff] && (dm_ff != '0));
            ax_ff         <= ~ax_ff;
         end
         ST_OUT: if (rsp_xfer) seg_ff <= seg_ff + SEG_W'(1);
         default: ;
      endcase
   end

endmodule

/* bench/step_checker.sv */
// step_checker: watches the req_ and rsp_ streams of the vector move step
// generator, predicts each segment's step counts and compares; depends on vmsg_pkg
module step_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [vmsg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [vmsg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vmsg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output int                              fail_count,
   output int                              pending_segments,
   output int                              segments_seen
);
   import vmsg_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0] x_steps;
      logic             x_fwd;
      logic [CNT_W-1:0] z_steps;
      logic             z_fwd;
      logic             last;
   } segment_type;

   segment_type       segment_queue[$];
   logic [RATE_W-1:0] x_rate, z_rate;
   logic [SEG_W-1:0]  seg_cfg;
   longint            x_res, z_res;

   assign pending_segments = segment_queue.size();

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_table(int i);
      longint t[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                        20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return t[i];
   endfunction

   task automatic heading_trig(input logic [HEAD_W-1:0] hd, output longint cq,
                               output longint sq);
      longint ax, ay, az, xs, ys, c, s;
      ax = CORDIC_INV_GAIN;
      ay = 0;
      az = longint'(hd[13:0]) << 8;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = floor_shr(ax, i);
         ys = floor_shr(ay, i);
         if (az >= 0) begin
            ax -= ys; ay += xs; az -= atan_table(i);
         end else begin
            ax += ys; ay -= xs; az += atan_table(i);
         end
      end
      c = floor_shr(ax + 8192, 14);
      s = floor_shr(ay + 8192, 14);
      if (c > 65536) c = 65536;
      if (c < -65536) c = -65536;
      if (s > 65536) s = 65536;
      if (s < -65536) s = -65536;
      case (hd[15:14])
         2'd0: begin cq = c; sq = s; end
         2'd1: begin cq = -s; sq = c; end
         2'd2: begin cq = -c; sq = -s; end
         default: begin cq = s; sq = -c; end
      endcase
   endtask

   function automatic logic [CNT_W-1:0] accumulate_steps(longint delta,
         logic [RATE_W-1:0] rate, ref longint res);
      longint v, mag, q, total, tmag, whole;
      v = delta * longint'(rate);
      mag = (v < 0) ? -v : v;
      q = (mag + 32768) >> 16;
      if (v < 0) q = -q;
      total = q + res;
      tmag = (total < 0) ? -total : total;
      whole = tmag >> 16;
      res = (total < 0) ? -(tmag & 16'hFFFF) : (tmag & 16'hFFFF);
      return (whole > 65535) ? 16'hFFFF : whole[15:0];
   endfunction

   task automatic split_vector(input logic [REQ_DATA_W-1:0] d);
      longint len, cq, sq, px, pz, nx, nz, px_prev, pz_prev, dx, dz, n;
      segment_type seg;
      len = longint'($signed(d[16:0]));
      n = seg_cfg;
      if (n < 1) n = 1;
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      heading_trig(d[32:17], cq, sq);
      px = len * cq;
      pz = len * sq;
      px_prev = 0;
      pz_prev = 0;
      for (longint i = 1; i <= n; i++) begin
         nx = (px * i) / n;
         nz = (pz * i) / n;
         dx = nx - px_prev;
         dz = nz - pz_prev;
         seg.x_steps = accumulate_steps(dx, x_rate, x_res);
         seg.x_fwd   = dx >= 0;
         seg.z_steps = accumulate_steps(dz, z_rate, z_res);
         seg.z_fwd   = dz >= 0;
         seg.last    = i == n;
         segment_queue.push_back(seg);
         px_prev = nx;
         pz_prev = nz;
      end
   endtask

   always @(posedge clock) begin
      segment_type got, want;
      if (reset) begin
         x_rate <= X_RATE_RESET;
         z_rate <= Z_RATE_RESET;
         seg_cfg <= SEG_RESET;
         x_res = 0;
         z_res = 0;
         segment_queue.delete();
         fail_count <= 0;
         segments_seen <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               REG_X_RATE: x_rate <= csr_pwdata[15:0];
               REG_Z_RATE: z_rate <= csr_pwdata[15:0];
               REG_SEGS:   seg_cfg <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) split_vector(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            segments_seen <= segments_seen + 1;
            got = {rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[32:17], rsp_tdata[33],
                   rsp_tlast};
            if (segment_queue.size() == 0) begin
               $display("%0t: unexpected transfer, got %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = segment_queue.pop_front();
               if (got != want) begin
                  $display("%0t: segment mismatch, expected %p, got %p",
                           $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for the vector move step generator; drives
// move vectors and register writes, with step_checker alongside the block
module tb_top;
   import vmsg_pkg::*;

   localparam logic [1:0] REG_SPARE = 2'd3;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tlast;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata, csr_prdata;
   int                    fail_count, pending_segments, segments_seen;
   int                    send_idle_pct, recv_idle_pct, vectors_sent;
   logic                  hold_rsp;

   vector_move_step_generator u_dut (.*);

   step_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_vector(logic [16:0] len, logic [15:0] hd);
      req_tvalid <= 1;
      req_tdata <= {7'd0, hd, len};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 0;
      vectors_sent++;
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
   endtask

   task automatic drain;
      repeat (2) @(posedge clock);
      while (pending_segments != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic random_vector;
      logic [16:0] len;
      case ($urandom_range(3))
         0: len = 17'($urandom);
         1: len = 17'($urandom_range(2000));
         2: len = 17'(-$urandom_range(2000));
         default: len = $urandom_range(1) ? 17'h0FFFF : 17'h10000;
      endcase
      send_vector(len, 16'($urandom));
   endtask

   initial begin
      reset = 1; req_tvalid = 0; req_tdata = '0; hold_rsp = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 9; recv_idle_pct = 80; vectors_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, quadrants, default registers
      send_vector(17'h0FFFF, 16'd0);
      send_vector(17'h10000, 16'd16384);
      send_vector(17'd0, 16'hFFFF);
      send_vector(17'd256, 16'd32768);
      send_vector(17'h1FF00, 16'd49152);
      send_vector(17'd1000, 16'd8192);
      drain();
      csr_write(REG_SEGS, 32'd0);
      csr_write(REG_X_RATE, 32'hFFFF);
      csr_write(REG_Z_RATE, 32'd0);
      send_vector(17'h0FFFF, 16'd8192);
      send_vector(17'h10000, 16'd40000);
      send_vector(17'd3, 16'd1);
      drain();
      csr_write(REG_SEGS, 32'd127);
      csr_write(REG_X_RATE, 32'd0);
      csr_write(REG_Z_RATE, 32'hFFFF);
      csr_write(REG_SPARE, 32'd5);
      send_vector(17'h0FFFF, 16'd24576);
      send_vector(17'h1FFFF, 16'd60000);
      drain();
      csr_write(REG_SEGS, 32'd1);
      csr_write(REG_X_RATE, 32'd1869);
      csr_write(REG_Z_RATE, 32'd1894);
      for (int i = 0; i < 8; i++) send_vector(17'h0FFFF, 16'(i * 8192 + 5));

      // long receiver hold so the block backs up and stalls its input
      hold_rsp <= 1;
      fork
         begin repeat (400) @(posedge clock); hold_rsp <= 0; end
         for (int i = 0; i < 6; i++) random_vector();
      join
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 9 : phase == 1 ? 80 : 0;
         recv_idle_pct = phase == 0 ? 80 : phase == 1 ? 9 : 0;
         for (int k = 0; k < 4; k++) begin
            drain();
            csr_write(REG_SEGS, $urandom_range(3) == 0 ? 32'd64 : $urandom_range(1, 8));
            csr_write(REG_X_RATE, $urandom_range(3) == 0 ? $urandom : $urandom_range(4000));
            csr_write(REG_Z_RATE, $urandom_range(3) == 0 ? $urandom : $urandom_range(4000));
            for (int j = 0; j < 19; j++) random_vector();
         end
      end
      drain();
      $display("covered %0d move vectors and %0d segment transfers", vectors_sent,
               segments_seen);
      $display("across several rate and segment settings with both sides stalling");
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/vmsg_pkg.sv
hw/rtl/vector_move_step_generator.sv
bench/step_checker.sv
bench/tb_top.sv
